@@ design/gtbd_pkg.sv @@
// ----------------------------------------------------------------------------
// gtbd_pkg
// Shared types, register indexes and the dither matrix function for the
// gray to binary dither block.
// ----------------------------------------------------------------------------
package gtbd_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_MODE        = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD   = 2'd1;
  localparam logic [1:0] CFG_MATRIX_LOG2 = 2'd2;
  localparam logic [1:0] CFG_LINE_WIDTH  = 2'd3;

  // mode codes (the unused code acts as threshold)
  localparam logic [1:0] MODE_THRESHOLD = 2'd0;
  localparam logic [1:0] MODE_ORDERED   = 2'd1;
  localparam logic [1:0] MODE_BLOCK     = 2'd2;

  // register reset values
  localparam logic [1:0]  MODE_RESET        = MODE_THRESHOLD;
  localparam logic [7:0]  THRESHOLD_RESET   = 8'd128;
  localparam logic [1:0]  MATRIX_LOG2_RESET = 2'd2;
  localparam logic [12:0] LINE_WIDTH_RESET  = 13'd640;

  // scaled gray level, at most 64
  localparam int LEVEL_W = 7;

  // entries held between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  threshold;
    logic [1:0]  matrix_log2;
    logic [12:0] line_width;
  } gtbd_cfg_t;

  // one classified pixel
  typedef struct packed {
    logic               block;
    logic               white;
    logic [1:0]         k;
    logic [LEVEL_W-1:0] level;
  } gtbd_task_t;

  // recursive bayer matrix entry for side 2**k, k in 1..3
  function automatic logic [5:0] dither_entry(input logic [1:0] k,
                                              input logic [2:0] r,
                                              input logic [2:0] c);
    logic [5:0] v;
    logic [1:0] quad;
    v = {4'd0, c[0], r[0]};
    for (int j = 1; j < 3; j++) begin
      quad = {r[j] ^ c[j], r[j]};
      if (j < int'(k)) begin
        v = {v[3:0], quad};
      end
    end
    return v;
  endfunction

endpackage

@@ design/gtbd_fifo.sv @@
// ----------------------------------------------------------------------------
// gtbd_fifo
// Small register queue between the front and the back of the dither block.
// Head entry is presented directly from the storage registers.
// ----------------------------------------------------------------------------
module gtbd_fifo #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full       = (count == (AW+1)'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = store[rd_ptr];

  // storage writes
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

@@ design/gtbd_front.sv @@
// ----------------------------------------------------------------------------
// gtbd_front
// Accepts gray pixels, scales them, resolves point-mode results and tracks
// the raster position. Each pixel leaves as one task for the back end.
// ----------------------------------------------------------------------------
module gtbd_front #(
  parameter int MAX_LINE_WIDTH  = 4096,
  parameter int MAX_MATRIX_LOG2 = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  gtbd_pkg::gtbd_cfg_t cfg,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] gray_level
  input  logic                q_full,
  output logic                q_push,
  output gtbd_pkg::gtbd_task_t q_task
);

  import gtbd_pkg::*;

  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int WW = (CW + 1 > 13) ? CW + 1 : 13;
  localparam logic [1:0] KMAX = 2'(MAX_MATRIX_LOG2);

  logic [CW-1:0]      col;
  logic [2:0]         row_phase;
  logic [1:0]         k_eff;
  logic [2:0]         mask;
  logic [6:0]         scale;
  logic [14:0]        prod;
  logic [LEVEL_W-1:0] level;
  logic [CW+2:0]      col_ext;
  logic [5:0]         ord_entry;
  logic               white;
  logic [WW-1:0]      width_eff;
  logic [CW:0]        col_inc;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // matrix size, saturated into range
  always_comb begin
    k_eff = cfg.matrix_log2;
    if (k_eff < 2'd1) begin
      k_eff = 2'd1;
    end
    if (k_eff > KMAX) begin
      k_eff = KMAX;
    end
  end

  // scaled level: gray * (n*n + 1) >> 8
  assign mask  = 3'((4'd1 << k_eff) - 4'd1);
  assign scale = (7'd1 << {k_eff, 1'b0}) + 7'd1;
  assign prod  = 15'(s_tdata) * 15'(scale);
  assign level = prod[14:8];

  // point mode decision
  assign col_ext   = (CW+3)'(col);
  assign ord_entry = dither_entry(k_eff, row_phase & mask, col_ext[2:0] & mask);

  always_comb begin
    if (cfg.mode == MODE_ORDERED) begin
      white = (level > 7'(ord_entry));
    end else begin
      white = (s_tdata >= cfg.threshold);
    end
  end

  always_comb begin
    q_task.block = (cfg.mode == MODE_BLOCK);
    q_task.white = white;
    q_task.k     = k_eff;
    q_task.level = level;
  end

  // effective line width
  always_comb begin
    width_eff = WW'(cfg.line_width);
    if (width_eff == '0) begin
      width_eff = WW'(1);
    end
    if (width_eff > WW'(MAX_LINE_WIDTH)) begin
      width_eff = WW'(MAX_LINE_WIDTH);
    end
  end

  assign col_inc = (CW+1)'(col) + (CW+1)'(1);

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row_phase <= '0;
    end else if (q_push) begin
      if (WW'(col_inc) >= width_eff) begin
        col       <= '0;
        row_phase <= row_phase + 3'd1;
      end else begin
        col <= col_inc[CW-1:0];
      end
    end
  end

`ifndef SYNTH
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    WW'(col) < WW'(MAX_LINE_WIDTH))
    else $error("column beyond largest line width");
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    q_push && (WW'(col_inc) >= width_eff) |=>
      (col == '0) && (row_phase == $past(row_phase) + 3'd1))
    else $error("line end did not wrap the position");
  a_hold_position: assert property (@(posedge clk) disable iff (rst)
    !q_push |=> $stable(col) && $stable(row_phase))
    else $error("position moved without an item");
`endif

endmodule

@@ design/gtbd_back.sv @@
// ----------------------------------------------------------------------------
// gtbd_back
// Works off queued tasks: one result for point modes, n*n results in raster
// order for block mode, into a registered output stage.
// ----------------------------------------------------------------------------
module gtbd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  gtbd_pkg::gtbd_task_t head,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [0] pixel_white, [3:1] sub_row, [6:4] sub_col, [7] zero
  output logic                 m_tlast    // last_of_pixel
);

  import gtbd_pkg::*;

  logic [2:0] r_cnt;
  logic [2:0] c_cnt;
  logic [2:0] mask;
  logic [5:0] entry;
  logic       advance;
  logic       last;
  logic       white;
  logic [2:0] sub_row;
  logic [2:0] sub_col;

  assign advance = head_valid && (!m_tvalid || m_tready);
  assign mask    = 3'((4'd1 << head.k) - 4'd1);
  assign entry   = dither_entry(head.k, r_cnt, c_cnt);

  // result of the current sub-pixel
  always_comb begin
    if (head.block) begin
      white   = (head.level >= 7'(entry));
      sub_row = r_cnt;
      sub_col = c_cnt;
      last    = (r_cnt == mask) && (c_cnt == mask);
    end else begin
      white   = head.white;
      sub_row = '0;
      sub_col = '0;
      last    = 1'b1;
    end
  end

  assign pop = advance && last;

  // block sub-pixel counters
  always_ff @(posedge clk) begin
    if (rst) begin
      r_cnt <= '0;
      c_cnt <= '0;
    end else if (advance && head.block) begin
      if (last) begin
        r_cnt <= '0;
        c_cnt <= '0;
      end else if (c_cnt == mask) begin
        c_cnt <= '0;
        r_cnt <= r_cnt + 3'd1;
      end else begin
        c_cnt <= c_cnt + 3'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, sub_col, sub_row, white};
      m_tlast <= last;
    end
  end

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("output valid after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(r_cnt) && $stable(c_cnt))
    else $error("sub-pixel counters moved under stall");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    head_valid && head.block |-> ((r_cnt & ~mask) == 3'd0) && ((c_cnt & ~mask) == 3'd0))
    else $error("sub-pixel counter beyond matrix");
`endif

endmodule

@@ design/gray_to_binary_dither_top.sv @@
// ----------------------------------------------------------------------------
// gray_to_binary_dither_top
// Gray pixel stream to binary pixels by threshold, ordered or block dither.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one 8-bit gray pixel per item, in raster order.
//   m_* carries binary results: white flag, block sub_row/sub_col, and tlast
//   on the final result of each pixel.
//   cfg_* writes mode (0), threshold (1), matrix_log2 (2), line_width (3);
//   cfg_ready is always high; write only while no pixel is in flight.
// Path: an accepted pixel is first written into the queue; when the queue is empty and
//   the output register is free, its first result is then captured in the output register.
// Throughput: threshold and ordered modes take one pixel per cycle while m_tready stays high;
//   block mode gives n*n results per pixel (4, 16 or 64), as the back end emits
//   one sub-pixel per cycle while m_tready stays high.
// A 4-entry queue sits between pixel intake and result generation, so intake
//   runs ahead while results drain.
// Reset: registers return to their defaults (threshold mode, threshold 128,
//   n = 4, line width 640), raster position goes to the start, queue empties.
// Receiver stall: the output register holds, the queue fills, and s_tready
//   drops once four pixels are waiting.
// ----------------------------------------------------------------------------
module gray_to_binary_dither_top #(
  parameter int MAX_LINE_WIDTH  = 4096,
  parameter int MAX_MATRIX_LOG2 = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] gray_level
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [0] pixel_white, [3:1] sub_row, [6:4] sub_col, [7] zero
  output logic        m_tlast,    // last_of_pixel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  import gtbd_pkg::*;

  gtbd_cfg_t  cfg;
  gtbd_task_t push_task;
  gtbd_task_t head_task;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_head_valid;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_RESET;
      cfg.threshold   <= THRESHOLD_RESET;
      cfg.matrix_log2 <= MATRIX_LOG2_RESET;
      cfg.line_width  <= LINE_WIDTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:        cfg.mode        <= cfg_data[1:0];
        CFG_THRESHOLD:   cfg.threshold   <= cfg_data[7:0];
        CFG_MATRIX_LOG2: cfg.matrix_log2 <= cfg_data[1:0];
        CFG_LINE_WIDTH:  cfg.line_width  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // pixel intake and classification
  gtbd_front #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .MAX_MATRIX_LOG2(MAX_MATRIX_LOG2)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_task  (push_task)
  );

  // task queue
  gtbd_fifo #(
    .WIDTH($bits(gtbd_task_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_task),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_data (head_task)
  );

  // result generation
  gtbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(q_head_valid),
    .head      (head_task),
    .pop       (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
